// File: rtl/sgfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer engine package
// Shared constants, operation codes, pixel request type and the 5x8 font ROM.
// ----------------------------------------------------------------------------
package sgfe_pkg;

  // Default panel geometry
  localparam int PANEL_WIDTH_DEF  = 64;
  localparam int PANEL_HEIGHT_DEF = 128;

  // Byte values used by the fill operation and the pixel mask
  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [7:0] MASK_BIT0  = 8'h01;

  // Glyph geometry
  localparam int         GLYPH_COLS     = 5;
  localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
  localparam logic [2:0] GLYPH_LAST_BIT = 3'd7;

  // Operation codes
  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_GLYPH = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // One pixel request from the glyph walker
  typedef struct packed {
    logic       valid;
    logic [7:0] px;
    logic [7:0] py;
  } pix_req_t;

  // Font: five column bytes per glyph, bit 0 is the top row
  localparam logic [7:0] GLYPH_ROM [64][GLYPH_COLS] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
    '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78}, '{8'h7F, 8'h48, 8'h44, 8'h44, 8'h38},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20}, '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7F},
    '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18}, '{8'h08, 8'h7E, 8'h09, 8'h01, 8'h02},
    '{8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E}, '{8'h7F, 8'h08, 8'h04, 8'h04, 8'h78},
    '{8'h00, 8'h44, 8'h7D, 8'h40, 8'h00}, '{8'h20, 8'h40, 8'h44, 8'h3D, 8'h00},
    '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00}, '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00},
    '{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h78},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38}, '{8'h7C, 8'h14, 8'h14, 8'h14, 8'h08},
    '{8'h08, 8'h14, 8'h14, 8'h18, 8'h7C}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08},
    '{8'h48, 8'h54, 8'h54, 8'h54, 8'h20}, '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20},
    '{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C}, '{8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C},
    '{8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
    '{8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C}, '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44},
    '{8'h54, 8'h00, 8'h04, 8'h00, 8'h08}
  };

endpackage

// File: rtl/sgfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module sgfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sgfe_glyph_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph walker
// Steps through glyph column, column repeat, bit row and row repeat, one
// position per cycle, and emits one pixel request per repeat of a set bit.
// ----------------------------------------------------------------------------
module sgfe_glyph_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        origin_x_i,
  input  logic [7:0]        origin_y_i,
  input  logic [5:0]        glyph_i,
  input  logic [3:0]        scale_x_i,
  input  logic [3:0]        scale_y_i,
  output sgfe_pkg::pix_req_t pix_o,
  output logic              busy_o
);

  import sgfe_pkg::*;

  logic       run_q, run_d;
  logic [2:0] col_q, col_d;
  logic [3:0] sx_q, sx_d;
  logic [2:0] bit_q, bit_d;
  logic [3:0] sy_q, sy_d;
  logic [7:0] row_q, row_d;
  logic [7:0] column_q, column_d;
  logic [7:0] oy_q, oy_d;
  logic [5:0] glyph_q, glyph_d;
  logic [3:0] scx_q, scx_d;
  logic [3:0] scy_q, scy_d;
  logic [7:0] col_bits;
  logic       bit_set;

  // Look up the current glyph bit
  assign col_bits = GLYPH_ROM[glyph_q][col_q];
  assign bit_set  = col_bits[bit_q];

  // Advance the walk; row and column run as wrapping 8-bit counters
  always_comb begin
    run_d    = run_q;
    col_d    = col_q;
    sx_d     = sx_q;
    bit_d    = bit_q;
    sy_d     = sy_q;
    row_d    = row_q;
    column_d = column_q;
    oy_d     = oy_q;
    glyph_d  = glyph_q;
    scx_d    = scx_q;
    scy_d    = scy_q;
    if (start_i) begin
      run_d    = (scale_x_i != 4'd0) && (scale_y_i != 4'd0);
      col_d    = 3'd0;
      sx_d     = 4'd0;
      bit_d    = 3'd0;
      sy_d     = 4'd0;
      row_d    = origin_x_i;
      column_d = origin_y_i;
      oy_d     = origin_y_i;
      glyph_d  = glyph_i;
      scx_d    = scale_x_i;
      scy_d    = scale_y_i;
    end else if (run_q) begin
      if (bit_set && (sy_q != scy_q - 4'd1)) begin
        sy_d     = sy_q + 4'd1;
        column_d = column_q + 8'd1;
      end else begin
        sy_d = 4'd0;
        if (bit_q == GLYPH_LAST_BIT) begin
          bit_d    = 3'd0;
          column_d = oy_q;
          row_d    = row_q + 8'd1;
          if (sx_q == scx_q - 4'd1) begin
            sx_d = 4'd0;
            if (col_q == GLYPH_LAST_COL) begin
              run_d = 1'b0;
            end else begin
              col_d = col_q + 3'd1;
            end
          end else begin
            sx_d = sx_q + 4'd1;
          end
        end else begin
          bit_d    = bit_q + 3'd1;
          column_d = bit_set ? column_q + 8'd1 : column_q + {4'd0, scy_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q    <= col_d;
    sx_q     <= sx_d;
    bit_q    <= bit_d;
    sy_q     <= sy_d;
    row_q    <= row_d;
    column_q <= column_d;
    oy_q     <= oy_d;
    glyph_q  <= glyph_d;
    scx_q    <= scx_d;
    scy_q    <= scy_d;
  end

  // Emit one request per set-bit position: panel column across, row along
  assign pix_o.valid = run_q && bit_set;
  assign pix_o.px    = column_q;
  assign pix_o.py    = row_q;
  assign busy_o      = run_q;

endmodule

// File: rtl/scaled_glyph_framebuffer_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer engine
// Page-organised monochrome framebuffer with fill, pixel, scaled glyph and
// byte read operations, one request at a time, one result per request.
// ----------------------------------------------------------------------------
// A result follows only once its writes have landed. A fill sweeps all
//   STORE_BYTES entries; a glyph walks 5*scale_x column repeats of 8 bit
//   rows, repeating each set bit scale_y times.
// Throughput: one request at a time, one framebuffer read-modify-write a cycle.
// Reset: a clearing pass writes zero to all STORE_BYTES entries (1024 by
//   default) with in_stall_o held high.
// ----------------------------------------------------------------------------
module scaled_glyph_framebuffer_engine_unit #(
  parameter int PANEL_WIDTH  = sgfe_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = sgfe_pkg::PANEL_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic       color_i,
  input  logic [5:0] glyph_i,
  input  logic [3:0] scale_x_i,
  input  logic [3:0] scale_y_i,
  input  logic [9:0] address_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  import sgfe_pkg::*;

  localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_FILL  = 8'b0000_0100,
    ST_PIXEL = 8'b0000_1000,
    ST_GLYPH = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_READ  = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Request fields held for the running operation
  logic [7:0]        x_q, y_q;
  logic              color_q;
  logic [9:0]        addr_q;
  logic              is_read_q, is_read_d;
  logic [7:0]        fill_byte_q, fill_byte_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              sweep_act, sweep_last;

  // Pixel issue and read-modify-write stage
  pix_req_t          seq_pix;
  logic              seq_busy;
  logic              seq_start;
  logic              req_valid;
  logic [7:0]        req_px, req_py;
  logic              req_white;
  logic              on_panel, pix_issue;
  logic [ADDR_W-1:0] pix_addr;
  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [7:0]        s1_mask_q;
  logic              s1_white_q;
  logic              wr_valid_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [7:0]        wr_data_q;
  logic [7:0]        base_byte, new_byte;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_free, in_accept, addr_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign seq_start  = in_accept && (op_e'(op_i) == OP_GLYPH);
  assign sweep_act  = (state_q == ST_CLEAR) || (state_q == ST_FILL);
  assign sweep_last = (sweep_q == ADDR_W'(STORE_BYTES - 1));
  assign addr_ok    = (int'(addr_q) < STORE_BYTES);

  sgfe_glyph_seq u_glyph_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (seq_start),
    .origin_x_i (x_pos_i),
    .origin_y_i (y_pos_i),
    .glyph_i    (glyph_i),
    .scale_x_i  (scale_x_i),
    .scale_y_i  (scale_y_i),
    .pix_o      (seq_pix),
    .busy_o     (seq_busy)
  );

  // Select the pixel source: the held pixel request or the glyph walker
  always_comb begin
    req_valid = 1'b0;
    req_px    = x_q;
    req_py    = y_q;
    req_white = color_q;
    case (state_q)
      ST_PIXEL: begin
        req_valid = 1'b1;
      end
      ST_GLYPH: begin
        req_valid = seq_pix.valid;
        req_px    = seq_pix.px;
        req_py    = seq_pix.py;
        req_white = 1'b1;
      end
      default: begin
        req_valid = 1'b0;
      end
    endcase
  end

  // Clip to the panel and form the byte address
  assign on_panel  = ({1'b0, req_px} < 9'(PANEL_WIDTH)) &&
                     ({1'b0, req_py} < 9'(PANEL_HEIGHT));
  assign pix_issue = req_valid && on_panel;
  assign pix_addr  = ADDR_W'(int'(req_py[7:3]) * PANEL_WIDTH + int'(req_px));

  // Modify: forward the byte written last cycle if it is the same entry
  assign base_byte = (wr_valid_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : ram_rdata;
  assign new_byte  = s1_white_q ? (base_byte | s1_mask_q) : (base_byte & ~s1_mask_q);

  // Share the RAM ports between sweep, write-back and reads
  always_comb begin
    ram_we    = s1_valid_q;
    ram_waddr = s1_addr_q;
    ram_wdata = new_byte;
    if (sweep_act) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = fill_byte_q;
    end
    ram_re    = pix_issue || (state_q == ST_READ);
    ram_raddr = (state_q == ST_READ) ? ADDR_W'(addr_q) : pix_addr;
  end

  sgfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequence the operations
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    fill_byte_d = fill_byte_q;
    is_read_d   = is_read_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + ADDR_W'(1);
        if (sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          is_read_d = 1'b0;
          case (op_e'(op_i))
            OP_FILL: begin
              sweep_d     = '0;
              fill_byte_d = color_i ? BYTE_WHITE : BYTE_BLACK;
              state_d     = ST_FILL;
            end
            OP_PIXEL: state_d = ST_PIXEL;
            OP_GLYPH: state_d = ST_GLYPH;
            OP_READ: begin
              is_read_d = 1'b1;
              state_d   = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        sweep_d = sweep_q + ADDR_W'(1);
        if (sweep_last) begin
          state_d = ST_RESP;
        end
      end
      ST_PIXEL: begin
        state_d = ST_DRAIN;
      end
      ST_GLYPH: begin
        if (!seq_busy) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_q) begin
          state_d = ST_RESP;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = (is_read_q && addr_ok) ? ram_rdata : BYTE_BLACK;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      fill_byte_q <= BYTE_BLACK;
      out_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      wr_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      fill_byte_q <= fill_byte_d;
      out_valid_q <= out_valid_d;
      s1_valid_q  <= pix_issue;
      wr_valid_q  <= s1_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q     <= x_pos_i;
      y_q     <= y_pos_i;
      color_q <= color_i;
      addr_q  <= address_i;
    end
    is_read_q  <= is_read_d;
    out_data_q <= out_data_d;
    s1_addr_q  <= pix_addr;
    s1_mask_q  <= MASK_BIT0 << req_py[2:0];
    s1_white_q <= req_white;
    wr_addr_q  <= s1_addr_q;
    wr_data_q  <= new_byte;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // The write-back stage only carries pixel work from a drawing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ($past(state_q) == ST_PIXEL || $past(state_q) == ST_GLYPH))
    else $error("pixel write-back without a drawing operation");

  // Sweep writes never collide with a pixel write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR || state_q == ST_FILL) |-> !s1_valid_q)
    else $error("sweep overlaps pixel write-back");

  // A result is only formed once all writes have landed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |-> (!s1_valid_q && !seq_busy))
    else $error("result formed with writes still pending");

  // The glyph walker only runs while the glyph operation is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_pix.valid |-> (state_q == ST_GLYPH))
    else $error("glyph pixel outside glyph operation");

  // An accepted read goes straight to the RAM read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op_e'(op_i) == OP_READ) |=> (state_q == ST_READ))
    else $error("read request not issued");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer engine testbench
// Drives fill, pixel, glyph and read requests through the valid/stall
// handshake with bursty input and patterned output stalls. A shadow copy of
// the framebuffer predicts every read byte, and each result is checked in
// order against it.
// ----------------------------------------------------------------------------
module tb;
  import sgfe_pkg::*;

  localparam int    PANEL_W     = PANEL_WIDTH_DEF;
  localparam int    PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int    STORE_BYTES = PANEL_W * ((PANEL_H + 7) / 8);
  localparam int    RANDOM_REQS = 930;
  localparam int    LONG_HOLD   = 500;
  localparam real   HALF_PERIOD = 6.0;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_e;

  // Shadow framebuffer and queue of read bytes still due from the block
  class frame_scoreboard;
    logic [7:0] frame [STORE_BYTES];
    logic [7:0] due_bytes [$];
    int         errors;

    function new();
      foreach (frame[i]) frame[i] = BYTE_BLACK;
      errors = 0;
    endfunction

    // Set or clear one pixel, drop it when off the panel
    function void plot(int px, int py, bit white);
      int idx;
      if (px >= PANEL_W || py >= PANEL_H) return;
      idx = px + (py / 8) * PANEL_W;
      if (idx >= STORE_BYTES) return;
      frame[idx][py % 8] = white;
    endfunction

    // Apply one accepted request to the shadow store and queue its result
    function void note_request(op_e op, logic [7:0] x, logic [7:0] y, logic color,
                               logic [5:0] g, logic [3:0] sx, logic [3:0] sy,
                               logic [9:0] addr);
      logic [7:0] bits;
      int         row;
      int         column;
      logic [7:0] result;
      result = BYTE_BLACK;
      case (op)
        OP_FILL: begin
          foreach (frame[i]) frame[i] = color ? BYTE_WHITE : BYTE_BLACK;
        end
        OP_PIXEL: begin
          plot(x, y, color);
        end
        OP_GLYPH: begin
          // Glyph columns run down panel rows, glyph bits across panel columns
          for (int col = 0; col < GLYPH_COLS; col++) begin
            bits = GLYPH_ROM[g][col];
            for (int rx = 0; rx < sx; rx++) begin
              row = (int'(x) + col * int'(sx) + rx) & 'hFF;
              for (int rb = 0; rb < 8; rb++) begin
                if (bits[rb]) begin
                  for (int ry = 0; ry < sy; ry++) begin
                    column = (int'(y) + rb * int'(sy) + ry) & 'hFF;
                    plot(column, row, 1'b1);
                  end
                end
              end
            end
          end
        end
        default: begin
          if (addr < STORE_BYTES) result = frame[addr];
        end
      endcase
      due_bytes.push_back(result);
    endfunction

    // Compare one returned byte with the oldest one due
    function void check_result(logic [7:0] actual);
      logic [7:0] due;
      if (due_bytes.size() == 0) begin
        $error("read_data: unexpected result, expected none, actual %02h", actual);
        errors++;
        return;
      end
      due = due_bytes.pop_front();
      if (actual !== due) begin
        $error("read_data mismatch: expected %02h, actual %02h", due, actual);
        errors++;
      end
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] op_i        = OP_READ;
  logic [7:0] x_pos_i     = '0;
  logic [7:0] y_pos_i     = '0;
  logic       color_i     = 1'b0;
  logic [5:0] glyph_i     = '0;
  logic [3:0] scale_x_i   = '0;
  logic [3:0] scale_y_i   = '0;
  logic [9:0] address_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] read_data_o;

  frame_scoreboard sb = new();

  // Receiver state and long hold-off requests from the stimulus
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  stall_mode_e stall_mode    = STALL_NONE;
  int          mode_left     = 0;
  int          stall_phase   = 0;
  logic [9:0]  hot_addr      = '0;

  scaled_glyph_framebuffer_engine_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .x_pos_i    (x_pos_i),
    .y_pos_i    (y_pos_i),
    .color_i    (color_i),
    .glyph_i    (glyph_i),
    .scale_x_i  (scale_x_i),
    .scale_y_i  (scale_y_i),
    .address_i  (address_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .read_data_o(read_data_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Output stall pattern in randomly chosen modes, with long holds on request
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_ALTERNATE));
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 30);
        STALL_HEAVY:  out_stall_i <= (stall_phase % 4 != 0);
        default:      out_stall_i <= stall_phase[0];
      endcase
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(read_data_o);
  end

  // Offer one request and hold it until accepted
  task automatic offer(input op_e op, input logic [7:0] x, input logic [7:0] y,
                       input logic color, input logic [5:0] g, input logic [3:0] sx,
                       input logic [3:0] sy, input logic [9:0] addr);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i       <= op;
    x_pos_i    <= x;
    y_pos_i    <= y;
    color_i    <= color;
    glyph_i    <= g;
    scale_x_i  <= sx;
    scale_y_i  <= sy;
    address_i  <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(op, x, y, color, g, sx, sy, addr);
  endtask

  // Drop valid for a number of cycles
  task automatic idle(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Stop offering until every outstanding result has come back
  task automatic drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly small glyph scales, now and then the full range
  function automatic logic [3:0] pick_scale();
    if ($urandom_range(0, 49) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 3));
  endfunction

  // Build one random request, biased towards the panel and recent drawing
  task automatic random_request();
    int         r;
    op_e        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [9:0] addr;
    r = $urandom_range(0, 99);
    op = (r < 3) ? OP_FILL : (r < 33) ? OP_PIXEL : (r < 58) ? OP_GLYPH : OP_READ;
    x    = 8'($urandom);
    y    = 8'($urandom);
    addr = 10'($urandom);
    case (op)
      OP_PIXEL: begin
        if ($urandom_range(0, 4) != 0) begin
          x = 8'($urandom_range(0, PANEL_W - 1));
          y = 8'($urandom_range(0, PANEL_H - 1));
          hot_addr = 10'(x + (y / 8) * PANEL_W);
        end
      end
      OP_GLYPH: begin
        if ($urandom_range(0, 6) != 0) begin
          x = 8'($urandom_range(0, PANEL_H - 1));
          y = 8'($urandom_range(0, PANEL_W - 1));
          hot_addr = 10'(y + (x / 8) * PANEL_W);
        end
      end
      OP_READ: begin
        if ($urandom_range(0, 1) == 0) addr = hot_addr + 10'($urandom_range(0, 20));
      end
      default: ;
    endcase
    offer(op, x, y, 1'($urandom), 6'($urandom), pick_scale(), pick_scale(), addr);
  endtask

  // Give up if the run hangs
  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cleared store, fills, off-panel pixels, wrap, zero scale
    offer(OP_READ,  8'hFF, 8'hFF, 1'b1, 6'd63, 4'd15, 4'd15, 10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd1023);
    offer(OP_FILL,  8'hA5, 8'h5A, 1'b1, 6'd21, 4'd9,  4'd6,  10'd682);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd517);
    offer(OP_PIXEL, 8'd0,  8'd0,  1'b0, 6'd63, 4'd15, 4'd15, 10'd1023);
    offer(OP_PIXEL, 8'd63, 8'd127, 1'b0, 6'd0, 4'd0,  4'd0,  10'd0);
    offer(OP_PIXEL, 8'd64, 8'd5,  1'b0, 6'd0,  4'd0,  4'd0,  10'd0);
    offer(OP_PIXEL, 8'd5,  8'd128, 1'b0, 6'd0, 4'd0,  4'd0,  10'd0);
    offer(OP_PIXEL, 8'hFF, 8'hFF, 1'b0, 6'd0,  4'd0,  4'd0,  10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd1023);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd64);
    offer(OP_FILL,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd0);
    offer(OP_GLYPH, 8'd0,  8'd0,  1'b0, 6'd0,  4'd1,  4'd1,  10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd1);
    offer(OP_GLYPH, 8'd250, 8'd60, 1'b0, 6'd63, 4'd15, 4'd15, 10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd60);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd63);
    offer(OP_GLYPH, 8'd40, 8'd8,  1'b1, 6'd10, 4'd0,  4'd4,  10'd0);
    offer(OP_GLYPH, 8'd40, 8'd8,  1'b1, 6'd36, 4'd4,  4'd0,  10'd0);
    offer(OP_GLYPH, 8'd120, 8'd0, 1'b1, 6'd62, 4'd4,  4'd4,  10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd964);
    offer(OP_PIXEL, 8'd10, 8'd100, 1'b1, 6'd0, 4'd0,  4'd0,  10'd0);
    offer(OP_READ,  8'h00, 8'h00, 1'b0, 6'd0,  4'd0,  4'd0,  10'd778);
    drain();

    // Random bursts with gaps, one long output hold and one full drain
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_REQS; k++) begin
        random_request();
        sent++;
        if (sent == 300) hold_requests++;
        if (sent == 620) drain();
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
